[hw/rtl/lsc_pkg.sv]
// ----------------------------------------------------------------------------
// lsc_pkg
// shared types and constants of the lens shading correction pipeline
// ----------------------------------------------------------------------------
package lsc_pkg;

  localparam int MaxDimension = 4096;
  localparam int DimW         = 13;   // frame size register width
  localparam int PosW         = 12;   // pixel position width
  localparam int SampleW      = 8;
  localparam int CoefW        = 64;
  localparam int RadW         = 25;   // squared distance width
  localparam int AccW         = 130;  // wide two's complement accumulator
  localparam int DivW         = 128;  // unsigned divider width
  localparam int QuotW        = 8;
  localparam int CfgIdxW      = 3;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 3'd0,
    RegFrameHeight = 3'd1,
    RegCoefLinear  = 3'd2,
    RegCoefSquare  = 3'd3,
    RegCoefConst   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [SampleW-1:0] pixel_sample;
    logic [PosW-1:0]    pixel_column;
    logic [PosW-1:0]    pixel_row;
  } pix_in_t;

  typedef struct packed {
    logic [SampleW-1:0] corrected_sample;
    logic               denominator_bad;
  } pix_out_t;

  typedef struct packed {
    logic [SampleW-1:0] p;
    logic [RadW-1:0]    r;
  } rad_t;

  typedef struct packed {
    logic            x_neg;
    logic [DivW-1:0] x_mag;
    logic [DivW-1:0] y;
    logic            bad;
    logic            zero;
    logic            pnz;
  } den_t;

endpackage

[hw/rtl/lens_shading_correct.sv]
// ----------------------------------------------------------------------------
// lens_shading_correct
// radial polynomial lens shading gain, c*p/(a*r+b*r*r+c) rounded and clamped
// ----------------------------------------------------------------------------
// throughput: one request per cycle unless out_stall backs up a full pipe,
// set by the fully pipelined datapath
// (3 radius stages, 6 split-product denominator stages, 9 divider stages)
// stalls collapse bubbles stage by stage, nothing is dropped or repeated
// reset (rst, synchronous) empties the pipeline and restores the registers:
// 4096 x 4096 frame, a = b = 0, c = 1.0
module lens_shading_correct import lsc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // configuration writes
  input  logic               cfg_write,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CoefW-1:0]   cfg_data,
  // sample requests
  input  logic               in_valid,
  output logic               in_stall,
  input  pix_in_t            in_data,
  // corrected results
  output logic               out_valid,
  input  logic               out_stall,
  output pix_out_t           out_data
);

  logic [DimW-1:0]  frame_width, frame_height;
  logic [CoefW-1:0] coef_linear, coef_square, coef_const;

  // stage boundary handshakes
  logic rad_valid, rad_stall;
  rad_t rad_data;
  logic den_valid, den_stall;
  den_t den_data;

  // register file, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DimW'(MaxDimension);
      frame_height <= DimW'(MaxDimension);
      coef_linear  <= '0;
      coef_square  <= '0;
      coef_const   <= CoefW'(1) << 48;
    end else if (cfg_write) begin
      unique case (cfg_index)
        RegFrameWidth:  frame_width  <= cfg_data[DimW-1:0];
        RegFrameHeight: frame_height <= cfg_data[DimW-1:0];
        RegCoefLinear:  coef_linear  <= cfg_data;
        RegCoefSquare:  coef_square  <= cfg_data;
        RegCoefConst:   coef_const   <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared distance to the truncated frame centre
  lsc_radius u_radius (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (rad_valid),
    .out_stall    (rad_stall),
    .out_data     (rad_data)
  );

  // exact denominator in a wide accumulator, plus 2cp + D and 2D
  lsc_denom u_denom (
    .clk         (clk),
    .rst         (rst),
    .coef_linear (coef_linear),
    .coef_square (coef_square),
    .coef_const  (coef_const),
    .in_valid    (rad_valid),
    .in_stall    (rad_stall),
    .in_data     (rad_data),
    .out_valid   (den_valid),
    .out_stall   (den_stall),
    .out_data    (den_data)
  );

  // rounded quotient clamped at 255, bad denominator handling
  lsc_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (den_valid),
    .in_stall  (den_stall),
    .in_data   (den_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // a bad denominator only ever yields the two fixed codes
  a_bad_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.denominator_bad |->
      (out_data.corrected_sample == '0) || (out_data.corrected_sample == '1))
    else $error("bad denominator with unexpected sample");

  // the pipeline comes out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  // back pressure at the input only when the whole pipe is full and held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && rad_valid && den_valid)
    else $error("request stalled while pipeline has room");

endmodule

[hw/rtl/lsc_radius.sv]
// ----------------------------------------------------------------------------
// lsc_radius
// squared distance of the pixel to the frame centre, three stages
// ----------------------------------------------------------------------------
module lsc_radius import lsc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [DimW-1:0] frame_width,
  input  logic [DimW-1:0] frame_height,
  input  logic            in_valid,
  output logic            in_stall,
  input  pix_in_t         in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rad_t            out_data
);

  localparam int N = 3;

  logic [N-1:0]           v;
  logic [N:0]             adv;
  logic [DimW-1:0]        fw_sat, fh_sat;
  logic [DimW-1:0]        cx, cy;
  logic signed [DimW-1:0] dx, dy;
  logic [RadW-2:0]        sqx, sqy;
  logic [RadW-1:0]        r;
  logic [SampleW-1:0]     p0, p1, p2;
  logic signed [2*DimW-1:0] mx, my;

  always_comb begin
    adv[N] = !out_stall;
    for (int i = N - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];
  assign fw_sat = (frame_width > DimW'(MaxDimension)) ? DimW'(MaxDimension) : frame_width;
  assign fh_sat = (frame_height > DimW'(MaxDimension)) ? DimW'(MaxDimension) : frame_height;
  assign cx = fw_sat >> 1;
  assign cy = fh_sat >> 1;
  assign mx = dx * dx;
  assign my = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (adv[i]) begin
          v[i] <= (i == 0) ? in_valid : v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      dx <= $signed({1'b0, in_data.pixel_column}) - $signed(cx);
      dy <= $signed({1'b0, in_data.pixel_row}) - $signed(cy);
      p0 <= in_data.pixel_sample;
    end
    if (adv[1]) begin
      sqx <= mx[RadW-2:0];
      sqy <= my[RadW-2:0];
      p1  <= p0;
    end
    if (adv[2]) begin
      r  <= {1'b0, sqx} + {1'b0, sqy};
      p2 <= p1;
    end
  end

  assign out_valid  = v[N-1];
  assign out_data.p = p2;
  assign out_data.r = r;

endmodule

[hw/rtl/lsc_denom.sv]
// ----------------------------------------------------------------------------
// lsc_denom
// polynomial denominator and rounding numerator, six stages of split products
// ----------------------------------------------------------------------------
module lsc_denom import lsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [CoefW-1:0] coef_linear,
  input  logic [CoefW-1:0] coef_square,
  input  logic [CoefW-1:0] coef_const,
  input  logic             in_valid,
  output logic             in_stall,
  input  rad_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output den_t             out_data
);

  localparam int N = 6;

  logic [N-1:0] v;
  logic [N:0]   adv;

  // stage 0
  logic [2*RadW-1:0]   r2;
  logic [56:0]         a_lo_r;
  logic signed [57:0]  a_hi_r;
  logic [39:0]         c_lo_p;
  logic signed [40:0]  c_hi_p;
  logic [SampleW-1:0]  p0;
  // stage 1
  logic [56:0]         pll, plh;
  logic signed [57:0]  phl, phh;
  logic [AccW-1:0]     ar1, cp1;
  logic [SampleW-1:0]  p1;
  // stage 2
  logic [AccW-1:0]     br_l, br_h, arc2, cp2;
  logic [SampleW-1:0]  p2;
  // stage 3
  logic [AccW-1:0]     br3, arc3, cp3;
  logic [SampleW-1:0]  p3;
  // stage 4
  logic [AccW-1:0]     den4, cp4;
  logic [SampleW-1:0]  p4;
  // stage 5
  logic [AccW-1:0]     x5, y5;
  logic                bad5, zero5, pnz5;

  always_comb begin
    adv[N] = !out_stall;
    for (int i = N - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (adv[i]) begin
          v[i] <= (i == 0) ? in_valid : v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      r2     <= (2*RadW)'(in_data.r) * (2*RadW)'(in_data.r);
      a_lo_r <= 57'(coef_linear[31:0]) * 57'(in_data.r);
      a_hi_r <= $signed(coef_linear[63:32]) * $signed({1'b0, in_data.r});
      c_lo_p <= 40'(coef_const[31:0]) * 40'(in_data.p);
      c_hi_p <= $signed(coef_const[63:32]) * $signed({1'b0, in_data.p});
      p0     <= in_data.p;
    end
    if (adv[1]) begin
      pll <= 57'(coef_square[31:0]) * 57'(r2[24:0]);
      plh <= 57'(coef_square[31:0]) * 57'(r2[49:25]);
      phl <= $signed(coef_square[63:32]) * $signed({1'b0, r2[24:0]});
      phh <= $signed(coef_square[63:32]) * $signed({1'b0, r2[49:25]});
      ar1 <= {{40{a_hi_r[57]}}, a_hi_r, 32'b0} + {73'b0, a_lo_r};
      cp1 <= {{57{c_hi_p[40]}}, c_hi_p, 32'b0} + {90'b0, c_lo_p};
      p1  <= p0;
    end
    if (adv[2]) begin
      br_l <= {73'b0, pll} + {48'b0, plh, 25'b0};
      br_h <= {{72{phl[57]}}, phl} + {{47{phh[57]}}, phh, 25'b0};
      arc2 <= ar1 + {{66{coef_const[63]}}, coef_const};
      cp2  <= cp1;
      p2   <= p1;
    end
    if (adv[3]) begin
      br3  <= {br_h[97:0], 32'b0} + br_l;
      arc3 <= arc2;
      cp3  <= cp2;
      p3   <= p2;
    end
    if (adv[4]) begin
      den4 <= br3 + arc3;
      cp4  <= cp3;
      p4   <= p3;
    end
    if (adv[5]) begin
      // 2cp + D against 2D gives round to nearest, ties upward
      x5    <= {cp4[AccW-2:0], 1'b0} + den4;
      y5    <= {den4[AccW-2:0], 1'b0};
      zero5 <= (den4 == '0);
      bad5  <= den4[AccW-1] || (den4 == '0);
      pnz5  <= (p4 != '0);
    end
  end

  assign out_valid      = v[N-1];
  assign out_data.x_neg = x5[AccW-1];
  assign out_data.x_mag = x5[DivW-1:0];
  assign out_data.y     = y5[DivW-1:0];
  assign out_data.bad   = bad5;
  assign out_data.zero  = zero5;
  assign out_data.pnz   = pnz5;

endmodule

[hw/rtl/lsc_divide.sv]
// ----------------------------------------------------------------------------
// lsc_divide
// saturating 8-bit restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module lsc_divide import lsc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  den_t     in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pix_out_t out_data
);

  localparam int N = QuotW + 1;

  logic [N-1:0]     v;
  logic [N:0]       adv;
  logic [DivW-1:0]  rem [0:N-2];
  logic [DivW-1:0]  yv  [0:N-2];
  logic [QuotW-1:0] q   [0:N-1];
  logic             skip [0:N-1];
  logic             bad  [0:N-1];
  logic             zero [0:N-1];
  logic             pnz  [0:N-1];
  logic             sat;

  always_comb begin
    adv[N] = !out_stall;
    for (int i = N - 1; i >= 0; i--) begin
      adv[i] = !v[i] || adv[i+1];
    end
  end

  assign in_stall = !adv[0];
  assign sat = {8'b0, in_data.x_mag} >= {in_data.y, 8'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (adv[i]) begin
          v[i] <= (i == 0) ? in_valid : v[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem[0]  <= in_data.x_mag;
      yv[0]   <= in_data.y;
      // a negative rounding numerator means a zero quotient
      q[0]    <= (sat && !in_data.x_neg) ? '1 : '0;
      skip[0] <= sat || in_data.x_neg || in_data.bad;
      bad[0]  <= in_data.bad;
      zero[0] <= in_data.zero;
      pnz[0]  <= in_data.pnz;
    end
  end

  for (genvar s = 1; s < N; s++) begin : g_bit
    logic [DivW-1:0]  ysh;
    logic             take;
    logic [QuotW-1:0] qbit;
    assign ysh  = yv[s-1] << (QuotW - s);
    assign take = !skip[s-1] && (rem[s-1] >= ysh);
    assign qbit = take ? (QuotW'(1) << (QuotW - s)) : '0;

    always_ff @(posedge clk) begin
      if (adv[s]) begin
        q[s]    <= q[s-1] | qbit;
        skip[s] <= skip[s-1];
        bad[s]  <= bad[s-1];
        zero[s] <= zero[s-1];
        pnz[s]  <= pnz[s-1];
      end
    end

    if (s < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv[s]) begin
          rem[s] <= take ? rem[s-1] - ysh : rem[s-1];
          yv[s]  <= yv[s-1];
        end
      end
    end
  end

  assign out_valid                 = v[N-1];
  assign out_data.denominator_bad  = bad[N-1];
  assign out_data.corrected_sample = bad[N-1] ? ((zero[N-1] && pnz[N-1]) ? '1 : '0)
                                              : q[N-1];

endmodule
